@@ hdl/cfs_pkg.sv @@
package cfs_pkg;

    localparam int VALUE_W    = 32;
    localparam int ACC_W      = 56;
    localparam int DIFF_W     = ACC_W + 1;
    localparam int ORDER_W    = 4;
    localparam int FIELD_IX_W = 3;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic REQ_MATRIX    = 1'b0;
    localparam logic REQ_RHS       = 1'b1;
    localparam logic KIND_STATUS   = 1'b0;
    localparam logic KIND_SOLUTION = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_PD    = 2'd1,
        ST_NO_FACTOR = 2'd2,
        ST_SAT       = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_FACT,
        PH_FWD,
        PH_BACK
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW_INIT,
        S_TA,
        S_TB,
        S_MUL,
        S_ACC,
        S_BASE_RD,
        S_BASE,
        S_CHECK,
        S_OP,
        S_WB,
        S_STAT_OK,
        S_STAT_NPD,
        S_STAT_NOFAC,
        S_EMIT
    } state_t;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } iter_op_t;

    typedef struct packed {
        logic     load_mat;
        logic     load_rhs;
        logic     acc_clr;
        logic     opa_ld;
        logic     opa_from_sol;
        logic     mul_ld;
        logic     acc_ld;
        logic     base_ld;
        logic     solve_mode;
        logic     iter_start;
        iter_op_t iter_op;
        logic     wb_ram;
        logic     wb_sol;
        logic     wb_p;
        logic     flag_clr;
        logic     out_ld;
        logic     out_kind;
        logic     out_from_sol;
        logic     out_use_flag;
        status_t  out_status;
        logic     out_last;
    } cmd_t;

    typedef struct packed {
        logic out_valid;
        logic out_free;
        logic pivot_bad;
        logic iter_done;
    } stat_t;

endpackage

@@ hdl/cfs_ram.sv @@
module cfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                            wdata,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/cfs_iter.sv @@
// Shared multi-cycle unit: restoring divide (48 steps) or square root (24 steps).
module cfs_iter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  cfs_pkg::iter_op_t              op,
    input  logic [cfs_pkg::VALUE_W-1:0]    num,
    input  logic [cfs_pkg::VALUE_W-1:0]    den,
    output logic                           done,
    output logic [cfs_pkg::VALUE_W-1:0]    res,
    output logic                           sat
);
    import cfs_pkg::*;

    localparam logic [5:0] DIV_LAST  = 6'd47;
    localparam logic [5:0] SQRT_LAST = 6'd23;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    iter_op_t    op_reg;
    logic [47:0] work_reg;
    logic [32:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [23:0] root_reg;
    logic        neg_reg;
    logic        num_neg_reg;
    logic        zero_reg;

    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic        den_zero;
    logic [5:0]  cnt_last;

    logic [32:0] div_sh;
    logic        div_ge;
    logic [32:0] div_rem_next;
    logic [26:0] sq_sh;
    logic [26:0] sq_trial;
    logic        sq_ge;
    logic [26:0] sq_rem_next;

    assign num_mag  = num[31] ? (~num + 32'd1) : num;
    assign den_mag  = den[31] ? (~den + 32'd1) : den;
    assign den_zero = (den == '0);
    assign cnt_last = (op_reg == OP_DIV) ? DIV_LAST : SQRT_LAST;

    assign div_sh       = {rem_reg[31:0], work_reg[47]};
    assign div_ge       = div_sh >= {1'b0, dvs_reg};
    assign div_rem_next = div_ge ? (div_sh - {1'b0, dvs_reg}) : div_sh;

    assign sq_sh       = {rem_reg[24:0], work_reg[47:46]};
    assign sq_trial    = {1'b0, root_reg, 2'b01};
    assign sq_ge       = sq_sh >= sq_trial;
    assign sq_rem_next = sq_ge ? (sq_sh - sq_trial) : sq_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // divide by zero finishes at once
                if (op == OP_DIV && den_zero)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg && cnt_reg == cnt_last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg      <= op;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            root_reg    <= '0;
            dvs_reg     <= den_mag;
            neg_reg     <= num[31] ^ den[31];
            num_neg_reg <= num[31];
            zero_reg    <= (op == OP_DIV) && den_zero;
            work_reg    <= (op == OP_DIV) ? {num_mag, 16'd0} : {num, 16'd0};
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (op_reg == OP_DIV)
            begin
                rem_reg  <= div_rem_next;
                work_reg <= {work_reg[46:0], div_ge};
            end
            else
            begin
                rem_reg  <= 33'(sq_rem_next);
                root_reg <= {root_reg[22:0], sq_ge};
                work_reg <= {work_reg[45:0], 2'b00};
            end
        end
    end

    always_comb
    begin
        res = '0;
        sat = 1'b0;
        if (op_reg == OP_SQRT)
        begin
            res = {8'd0, root_reg};
        end
        else if (zero_reg)
        begin
            res = num_neg_reg ? 32'h8000_0000 : 32'h7fff_ffff;
            sat = 1'b1;
        end
        else if (neg_reg)
        begin
            if (work_reg > 48'h0000_8000_0000)
            begin
                res = 32'h8000_0000;
                sat = 1'b1;
            end
            else
            begin
                res = 32'(~work_reg + 48'd1);
            end
        end
        else
        begin
            if (work_reg > 48'h0000_7fff_ffff)
            begin
                res = 32'h7fff_ffff;
                sat = 1'b1;
            end
            else
            begin
                res = work_reg[31:0];
            end
        end
    end

    assign done = done_reg;

endmodule

@@ hdl/cfs_dp.sv @@
module cfs_dp #(
    parameter int MAX_ORDER = 8
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  cfs_pkg::cmd_t                                      cmd,
    input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER*MAX_ORDER) : 1)-1:0] ram_addr,
    input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0]           sol_idx,
    input  logic [cfs_pkg::FIELD_IX_W-1:0]                     out_idx,
    input  logic [cfs_pkg::VALUE_W-1:0]                        in_value,
    input  logic                                               out_ready,
    output cfs_pkg::stat_t                                     stat,
    output logic                                               out_valid,
    output logic                                               out_kind,
    output logic [cfs_pkg::FIELD_IX_W-1:0]                     out_index,
    output logic [cfs_pkg::VALUE_W-1:0]                        out_value,
    output cfs_pkg::status_t                                   out_status,
    output logic                                               out_last
);
    import cfs_pkg::*;

    logic [VALUE_W-1:0]        ram_rdata;
    logic [VALUE_W-1:0]        ram_wdata;
    logic                      ram_we;

    logic signed [VALUE_W-1:0] sol_reg [MAX_ORDER];
    logic signed [VALUE_W-1:0] opa_reg;
    logic signed [63:0]        prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [VALUE_W-1:0] diff_reg;
    logic [VALUE_W-1:0]        den_reg;
    logic [VALUE_W-1:0]        p_reg;
    logic                      flag_reg;

    logic                      out_valid_reg;
    logic                      out_kind_reg;
    logic [FIELD_IX_W-1:0]     out_index_reg;
    logic [VALUE_W-1:0]        out_value_reg;
    status_t                   out_status_reg;
    logic                      out_last_reg;

    logic signed [VALUE_W-1:0] sol_rd;
    logic signed [VALUE_W-1:0] base_val;
    logic signed [DIFF_W-1:0]  diff_full;
    logic                      ovf_pos;
    logic                      ovf_neg;
    logic [VALUE_W-1:0]        diff_sat;
    logic                      out_free;

    logic                      iter_done;
    logic [VALUE_W-1:0]        iter_res;
    logic                      iter_sat;

    assign ram_we    = cmd.load_mat | cmd.wb_ram;
    assign ram_wdata = cmd.load_mat ? in_value : iter_res;

    cfs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ORDER * MAX_ORDER)
    ) u_fstore (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    cfs_iter u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.iter_start),
        .op    (cmd.iter_op),
        .num   (diff_reg),
        .den   (cmd.solve_mode ? den_reg : p_reg),
        .done  (iter_done),
        .res   (iter_res),
        .sat   (iter_sat)
    );

    assign sol_rd    = sol_reg[sol_idx];
    assign base_val  = cmd.solve_mode ? sol_rd : $signed(ram_rdata);
    assign diff_full = DIFF_W'(base_val) - DIFF_W'(acc_reg);
    assign ovf_pos   = !diff_full[DIFF_W-1] && (|diff_full[DIFF_W-2:31]);
    assign ovf_neg   = diff_full[DIFF_W-1] && !(&diff_full[DIFF_W-2:31]);
    assign diff_sat  = ovf_pos ? 32'h7fff_ffff : (ovf_neg ? 32'h8000_0000 : diff_full[31:0]);
    assign out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_rhs)
        begin
            sol_reg[sol_idx] <= in_value;
        end
        else if (cmd.wb_sol)
        begin
            sol_reg[sol_idx] <= iter_res;
        end
        if (cmd.opa_ld)
        begin
            opa_reg <= cmd.opa_from_sol ? sol_rd : $signed(ram_rdata);
        end
        if (cmd.mul_ld)
        begin
            prod_reg <= opa_reg * $signed(ram_rdata);
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_ld)
        begin
            // arithmetic shift gives the floor of the Q16.16 product
            acc_reg <= acc_reg + ACC_W'(prod_reg >>> 16);
        end
        if (cmd.base_ld)
        begin
            diff_reg <= diff_sat;
            if (cmd.solve_mode)
            begin
                den_reg <= ram_rdata;
            end
        end
        if (cmd.wb_p)
        begin
            p_reg <= iter_res;
        end
        if (cmd.out_ld)
        begin
            out_kind_reg   <= cmd.out_kind;
            out_index_reg  <= out_idx;
            out_value_reg  <= cmd.out_from_sol ? sol_rd : '0;
            out_status_reg <= (cmd.out_use_flag && flag_reg) ? ST_SAT : cmd.out_status;
            out_last_reg   <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.flag_clr)
            begin
                flag_reg <= 1'b0;
            end
            else if ((cmd.base_ld && (ovf_pos || ovf_neg)) || (iter_done && iter_sat))
            begin
                flag_reg <= 1'b1;
            end
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_valid = out_valid_reg;
    assign stat.out_free  = out_free;
    assign stat.pivot_bad = diff_reg[VALUE_W-1] || (diff_reg == '0);
    assign stat.iter_done = iter_done;

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_index  = out_index_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule

@@ hdl/cfs_ctrl.sv @@
module cfs_ctrl #(
    parameter int MAX_ORDER = 8
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               in_valid,
    output logic                                               in_ready,
    input  logic                                               req_type,
    input  logic [cfs_pkg::FIELD_IX_W-1:0]                     row_index,
    input  logic [cfs_pkg::FIELD_IX_W-1:0]                     col_index,
    input  logic                                               last,
    input  logic                                               cfg_valid,
    output logic                                               cfg_ready,
    input  logic [cfs_pkg::ORDER_W-1:0]                        cfg_data,
    input  cfs_pkg::stat_t                                     stat,
    output cfs_pkg::cmd_t                                      cmd,
    output logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER*MAX_ORDER) : 1)-1:0] ram_addr,
    output logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0]           sol_idx,
    output logic [cfs_pkg::FIELD_IX_W-1:0]                     out_idx
);
    import cfs_pkg::*;

    localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1;
    localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int NW = $clog2(MAX_ORDER + 1);

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [NW-1:0]       c_reg, c_next;
    logic [NW-1:0]       i_reg, i_next;
    logic [NW-1:0]       k_reg, k_next;
    logic [NW-1:0]       e_reg, e_next;
    logic [ORDER_W-1:0]  order_reg, order_next;
    logic                fvalid_reg, fvalid_next;

    logic [NW-1:0]       n_cur;
    logic [NW-1:0]       k_start;
    logic [NW-1:0]       k_end;
    logic                idle_rdy;
    logic                accept;
    logic                row_ok;
    logic                mat_keep;
    logic                on_diag;

    function automatic logic [AW-1:0] at_addr(input logic [NW-1:0] r, input logic [NW-1:0] cc);
        return AW'(32'(r) * MAX_ORDER + 32'(cc));
    endfunction

    assign n_cur = (order_reg == '0) ? NW'(1) :
                   ((32'(order_reg) > MAX_ORDER) ? NW'(MAX_ORDER) : NW'(order_reg));

    assign idle_rdy  = (state_reg == S_IDLE) && !stat.out_valid;
    assign accept    = idle_rdy && in_valid;
    assign row_ok    = 32'(row_index) < MAX_ORDER;
    assign mat_keep  = row_ok && (col_index <= row_index);
    assign on_diag   = (phase_reg == PH_FACT) && (i_reg == c_reg);
    assign in_ready  = idle_rdy;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        unique case (phase_reg)
            PH_FACT:
            begin
                k_start = '0;
                k_end   = c_reg;
            end
            PH_FWD:
            begin
                k_start = '0;
                k_end   = i_reg;
            end
            PH_BACK:
            begin
                k_start = i_reg + NW'(1);
                k_end   = n_cur;
            end
            default:
            begin
                k_start = '0;
                k_end   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_FACT;
            c_reg      <= '0;
            i_reg      <= '0;
            k_reg      <= '0;
            e_reg      <= '0;
            order_reg  <= 4'd8;
            fvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            c_reg      <= c_next;
            i_reg      <= i_next;
            k_reg      <= k_next;
            e_reg      <= e_next;
            order_reg  <= order_next;
            fvalid_reg <= fvalid_next;
        end
    end

    // next state and loop counters
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        c_next      = c_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        e_next      = e_reg;
        order_next  = order_reg;
        fvalid_next = fvalid_reg;
        if (cfg_valid)
        begin
            order_next  = cfg_data;
            fvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_MATRIX)
                    begin
                        fvalid_next = 1'b0;
                        if (last)
                        begin
                            phase_next = PH_FACT;
                            c_next     = '0;
                            i_next     = '0;
                            state_next = S_ROW_INIT;
                        end
                    end
                    else if (last)
                    begin
                        if (fvalid_reg)
                        begin
                            phase_next = PH_FWD;
                            i_next     = '0;
                            state_next = S_ROW_INIT;
                        end
                        else
                        begin
                            state_next = S_STAT_NOFAC;
                        end
                    end
                end
            end
            S_ROW_INIT:
            begin
                k_next     = k_start;
                state_next = (k_start != k_end) ? S_TA : S_BASE_RD;
            end
            S_TA:      state_next = S_TB;
            S_TB:      state_next = S_MUL;
            S_MUL:     state_next = S_ACC;
            S_ACC:
            begin
                if (k_reg + NW'(1) == k_end)
                begin
                    state_next = S_BASE_RD;
                end
                else
                begin
                    k_next     = k_reg + NW'(1);
                    state_next = S_TA;
                end
            end
            S_BASE_RD: state_next = S_BASE;
            S_BASE:    state_next = S_CHECK;
            S_CHECK:   state_next = (on_diag && stat.pivot_bad) ? S_STAT_NPD : S_OP;
            S_OP:
            begin
                if (stat.iter_done)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                unique case (phase_reg)
                    PH_FACT:
                    begin
                        if (i_reg + NW'(1) != n_cur)
                        begin
                            i_next     = i_reg + NW'(1);
                            state_next = S_ROW_INIT;
                        end
                        else if (c_reg + NW'(1) != n_cur)
                        begin
                            c_next     = c_reg + NW'(1);
                            i_next     = c_reg + NW'(1);
                            state_next = S_ROW_INIT;
                        end
                        else
                        begin
                            fvalid_next = 1'b1;
                            state_next  = S_STAT_OK;
                        end
                    end
                    PH_FWD:
                    begin
                        if (i_reg + NW'(1) != n_cur)
                        begin
                            i_next = i_reg + NW'(1);
                        end
                        else
                        begin
                            phase_next = PH_BACK;
                            i_next     = n_cur - NW'(1);
                        end
                        state_next = S_ROW_INIT;
                    end
                    PH_BACK:
                    begin
                        if (i_reg != '0)
                        begin
                            i_next     = i_reg - NW'(1);
                            state_next = S_ROW_INIT;
                        end
                        else
                        begin
                            e_next     = '0;
                            state_next = S_EMIT;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_STAT_OK, S_STAT_NPD, S_STAT_NOFAC:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    if (e_reg + NW'(1) == n_cur)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        e_next = e_reg + NW'(1);
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd      = '0;
        ram_addr = '0;
        sol_idx  = '0;
        out_idx  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_addr     = at_addr(NW'(row_index), NW'(col_index));
                sol_idx      = IW'(row_index);
                cmd.load_mat = accept && (req_type == REQ_MATRIX) && mat_keep;
                cmd.load_rhs = accept && (req_type == REQ_RHS) && row_ok;
                cmd.flag_clr = accept && last;
            end
            S_ROW_INIT: cmd.acc_clr = 1'b1;
            S_TA:       ram_addr = at_addr(i_reg, k_reg);
            S_TB:
            begin
                cmd.opa_ld       = 1'b1;
                cmd.opa_from_sol = (phase_reg != PH_FACT);
                sol_idx          = IW'(k_reg);
                unique case (phase_reg)
                    PH_FACT: ram_addr = at_addr(c_reg, k_reg);
                    PH_FWD:  ram_addr = at_addr(i_reg, k_reg);
                    PH_BACK: ram_addr = at_addr(k_reg, i_reg);
                    default: ram_addr = '0;
                endcase
            end
            S_MUL:      cmd.mul_ld = 1'b1;
            S_ACC:      cmd.acc_ld = 1'b1;
            S_BASE_RD:
            begin
                ram_addr = (phase_reg == PH_FACT) ? at_addr(i_reg, c_reg) : at_addr(i_reg, i_reg);
            end
            S_BASE:
            begin
                cmd.base_ld    = 1'b1;
                cmd.solve_mode = (phase_reg != PH_FACT);
                sol_idx        = IW'(i_reg);
            end
            S_CHECK:
            begin
                cmd.solve_mode = (phase_reg != PH_FACT);
                cmd.iter_op    = on_diag ? OP_SQRT : OP_DIV;
                cmd.iter_start = !(on_diag && stat.pivot_bad);
            end
            S_OP:       cmd.solve_mode = (phase_reg != PH_FACT);
            S_WB:
            begin
                if (phase_reg == PH_FACT)
                begin
                    cmd.wb_ram = 1'b1;
                    cmd.wb_p   = on_diag;
                    ram_addr   = at_addr(i_reg, c_reg);
                end
                else
                begin
                    cmd.wb_sol = 1'b1;
                    sol_idx    = IW'(i_reg);
                end
            end
            S_STAT_OK:
            begin
                cmd.out_ld       = stat.out_free;
                cmd.out_kind     = KIND_STATUS;
                cmd.out_use_flag = 1'b1;
                cmd.out_status   = ST_OK;
                cmd.out_last     = 1'b1;
            end
            S_STAT_NPD:
            begin
                cmd.out_ld     = stat.out_free;
                cmd.out_kind   = KIND_STATUS;
                cmd.out_status = ST_NOT_PD;
                cmd.out_last   = 1'b1;
            end
            S_STAT_NOFAC:
            begin
                cmd.out_ld     = stat.out_free;
                cmd.out_kind   = KIND_SOLUTION;
                cmd.out_status = ST_NO_FACTOR;
                cmd.out_last   = 1'b1;
            end
            S_EMIT:
            begin
                cmd.out_ld       = stat.out_free;
                cmd.out_kind     = KIND_SOLUTION;
                cmd.out_from_sol = 1'b1;
                cmd.out_use_flag = 1'b1;
                cmd.out_status   = ST_OK;
                cmd.out_last     = (e_reg + NW'(1) == n_cur);
                sol_idx          = IW'(e_reg);
                out_idx          = FIELD_IX_W'(e_reg);
            end
            default: cmd = '0;
        endcase
    end

endmodule

@@ hdl/cholesky_factor_and_solve.sv @@
// Cholesky factor and solve, signed Q16.16. Matrix and right-hand-side elements
// load at one per cycle. A matrix element flagged last starts the in-place
// factorization, which ends in one status result; an rhs element flagged last
// starts forward and back substitution, which ends in n solution results, or in
// one no-factor result when no valid factor is held. All products run through
// one multiplier and all divides and roots through one shared iterative unit
// that divides one quotient bit per cycle or takes a square root two bits per
// cycle. Each entry reads, multiplies and accumulates its product terms, then
// forms its difference and divides, or takes a square root on the diagonal.
// Input is not taken during a run or while a result waits in the output
// register. The factor store is a 64-word RAM whose entries are undefined until
// loaded; the factor is only valid after a successful factorization.
module cholesky_factor_and_solve #(
    parameter int MAX_ORDER = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // row_index[2:0], col_index[5:3], value[37:6], zero[39:38]
    input  logic [cfs_pkg::IN_DATA_W-1:0]     s_tdata,
    // req_type
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // index[2:0], result_value[34:3], status[36:35], zero[39:37]
    output logic [cfs_pkg::OUT_DATA_W-1:0]    m_tdata,
    // kind
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cfs_pkg::ORDER_W-1:0]       cfg_data
);
    import cfs_pkg::*;

    localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1;
    localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    cmd_t                  cmd;
    stat_t                 stat;
    logic [AW-1:0]         ram_addr;
    logic [IW-1:0]         sol_idx;
    logic [FIELD_IX_W-1:0] out_idx;
    logic [FIELD_IX_W-1:0] out_index;
    logic [VALUE_W-1:0]    out_value;
    status_t               out_status;

    cfs_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .req_type  (s_tuser),
        .row_index (s_tdata[2:0]),
        .col_index (s_tdata[5:3]),
        .last      (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .cmd       (cmd),
        .ram_addr  (ram_addr),
        .sol_idx   (sol_idx),
        .out_idx   (out_idx)
    );

    cfs_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .ram_addr   (ram_addr),
        .sol_idx    (sol_idx),
        .out_idx    (out_idx),
        .in_value   (s_tdata[37:6]),
        .out_ready  (m_tready),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_kind   (m_tuser),
        .out_index  (out_index),
        .out_value  (out_value),
        .out_status (out_status),
        .out_last   (m_tlast)
    );

    assign m_tdata = {3'd0, out_status, out_value, out_index};

endmodule

@@ hdl/cfs_checker.sv @@
module cfs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cfs_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);
    import cfs_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_no_take_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input taken while a result waits");

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_STATUS) |-> m_tlast && (m_tdata[34:0] == '0))
        else $error("malformed factor status result");

    a_nofactor_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[36:35] == ST_NO_FACTOR) |-> m_tlast && (m_tuser == KIND_SOLUTION))
        else $error("malformed no-factor result");

endmodule

bind cholesky_factor_and_solve cfs_checker u_cfs_checker (.*);

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfs_pkg::*;

    typedef struct {
        logic        req;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] val;
        logic        lst;
    } elem_t;

    typedef struct {
        logic        kind;
        logic [2:0]  idx;
        logic [31:0] val;
        status_t     status;
        logic        lst;
    } answer_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [ORDER_W-1:0]    cfg_data;

    elem_t   pending_elems[$];
    answer_t answers_due[$];

    // predictor copy of the block state
    int   mat_mem[64];
    int   sol_mem[8];
    bit   fac_ok;
    int   order_reg;

    int   mismatches;
    int   items_sent;
    bit   press_arm;

    cholesky_factor_and_solve dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------- fixed-point predictor ----------------
    function automatic int clip32(longint x, inout bit fl);
        if (x > 64'sd2147483647)
        begin
            fl = 1'b1;
            return 32'sh7fffffff;
        end
        if (x < -64'sd2147483648)
        begin
            fl = 1'b1;
            return 32'sh80000000;
        end
        return int'(x);
    endfunction

    function automatic longint qmul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> 16;
    endfunction

    function automatic int qdiv(int num, int den, inout bit fl);
        if (den == 0)
        begin
            fl = 1'b1;
            return (num >= 0) ? 32'sh7fffffff : 32'sh80000000;
        end
        return clip32((longint'(num) * 65536) / longint'(den), fl);
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic int order_eff();
        if (order_reg == 0)
            return 1;
        if (order_reg > 8)
            return 8;
        return order_reg;
    endfunction

    function automatic status_t factor_matrix();
        int     n;
        bit     fl;
        longint s;
        int     d;
        int     p;
        n = order_eff();
        fl = 1'b0;
        for (int c = 0; c < n; c++)
        begin
            s = 0;
            for (int k = 0; k < c; k++)
                s += qmul(mat_mem[c*8+k], mat_mem[c*8+k]);
            d = clip32(longint'(mat_mem[c*8+c]) - s, fl);
            if (d <= 0)
                return ST_NOT_PD;
            p = clip32(root_floor(longint'(d) << 16), fl);
            mat_mem[c*8+c] = p;
            for (int i = c + 1; i < n; i++)
            begin
                s = 0;
                for (int k = 0; k < c; k++)
                    s += qmul(mat_mem[i*8+k], mat_mem[c*8+k]);
                mat_mem[i*8+c] = qdiv(clip32(longint'(mat_mem[i*8+c]) - s, fl), p, fl);
            end
        end
        fac_ok = 1'b1;
        return fl ? ST_SAT : ST_OK;
    endfunction

    function automatic void solve_into_answers();
        int      n;
        bit      fl;
        longint  s;
        answer_t a;
        n = order_eff();
        fl = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            s = 0;
            for (int j = 0; j < i; j++)
                s += qmul(sol_mem[j], mat_mem[i*8+j]);
            sol_mem[i] = qdiv(clip32(longint'(sol_mem[i]) - s, fl), mat_mem[i*8+i], fl);
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            s = 0;
            for (int j = i + 1; j < n; j++)
                s += qmul(sol_mem[j], mat_mem[j*8+i]);
            sol_mem[i] = qdiv(clip32(longint'(sol_mem[i]) - s, fl), mat_mem[i*8+i], fl);
        end
        for (int i = 0; i < n; i++)
        begin
            a.kind = KIND_SOLUTION;
            a.idx = i[2:0];
            a.val = sol_mem[i];
            a.status = fl ? ST_SAT : ST_OK;
            a.lst = (i == n - 1);
            answers_due.push_back(a);
        end
    endfunction

    // queue one request and predict what it causes
    function automatic void send_elem(logic req, int row, int col, logic [31:0] v, logic lst);
        elem_t   e;
        answer_t a;
        e.req = req;
        e.row = row[2:0];
        e.col = col[2:0];
        e.val = v;
        e.lst = lst;
        pending_elems.push_back(e);
        items_sent++;
        if (req == REQ_MATRIX)
        begin
            fac_ok = 1'b0;
            if (col <= row)
                mat_mem[row*8+col] = int'(v);
            if (lst)
            begin
                a.kind = KIND_STATUS;
                a.idx = 3'd0;
                a.val = 32'd0;
                a.status = factor_matrix();
                a.lst = 1'b1;
                answers_due.push_back(a);
            end
        end
        else
        begin
            sol_mem[row] = int'(v);
            if (lst)
            begin
                if (!fac_ok)
                begin
                    a.kind = KIND_SOLUTION;
                    a.idx = 3'd0;
                    a.val = 32'd0;
                    a.status = ST_NO_FACTOR;
                    a.lst = 1'b1;
                    answers_due.push_back(a);
                end
                else
                    solve_into_answers();
            end
        end
    endfunction

    function automatic int rnd_pm(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // ---------------- request driver ----------------
    int  gap_left;
    bit  send_calm;

    always @(posedge clk or negedge rst_n)
    begin
        elem_t e;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            s_tlast  <= 1'b0;
            gap_left = 0;
            send_calm = 1'b0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_elems.size() > 0)
            begin
                e = pending_elems.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, e.val, e.col, e.row};
                s_tuser  <= e.req;
                s_tlast  <= e.lst;
                if ($urandom_range(0, 39) == 0)
                    send_calm = !send_calm;
                gap_left = send_calm ? 0 : $urandom_range(0, 16);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ---------------- result monitor ----------------
    int  stall_left;
    int  hold_left;
    bit  pressed;
    bit  recv_calm;

    always @(posedge clk or negedge rst_n)
    begin
        answer_t a;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            pressed = 1'b0;
            recv_calm = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (answers_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0d index %0d value %h status %0d",
                                 m_tuser, m_tdata[2:0], m_tdata[34:3], m_tdata[36:35]);
                end
                else
                begin
                    a = answers_due.pop_front();
                    if (m_tuser !== a.kind || m_tdata[2:0] !== a.idx ||
                        m_tdata[34:3] !== a.val || m_tdata[36:35] !== a.status ||
                        m_tlast !== a.lst)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp k%0d i%0d v%h s%0d l%0d, ",
                                      "got k%0d i%0d v%h s%0d l%0d"},
                                     a.kind, a.idx, a.val, a.status, a.lst,
                                     m_tuser, m_tdata[2:0], m_tdata[34:3], m_tdata[36:35],
                                     m_tlast);
                    end
                end
                if ($urandom_range(0, 29) == 0)
                    recv_calm = !recv_calm;
                stall_left = recv_calm ? 0 : $urandom_range(0, 16);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (press_arm && !pressed && m_tvalid)
            begin
                // long back-pressure so the input side fills and stalls
                pressed = 1'b1;
                hold_left = 3000;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ---------------- stimulus ----------------
    task automatic wait_idle();
        while (pending_elems.size() != 0 || s_tvalid || answers_due.size() != 0)
            @(posedge clk);
        // loads without a result may still be in flight
        repeat (40) @(posedge clk);
    endtask

    task automatic write_order(int v);
        wait_idle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v[3:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        order_reg = v;
        fac_ok = 1'b0;
    endtask

    // mode 0: diagonally dominant, 1: full-range noise, 2: bad pivot
    task automatic load_matrix(int mode);
        int n;
        int rows[$];
        int cols[$];
        int j;
        int t;
        int bad;
        int r;
        int c;
        int uc;
        bit upper_last;
        logic [31:0] v;
        n = order_eff();
        for (int i = 0; i < n; i++)
            for (int k = 0; k <= i; k++)
            begin
                rows.push_back(i);
                cols.push_back(k);
            end
        for (int i = rows.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = rows[i]; rows[i] = rows[j]; rows[j] = t;
            t = cols[i]; cols[i] = cols[j]; cols[j] = t;
        end
        bad = $urandom_range(0, n - 1);
        upper_last = ($urandom_range(0, 5) == 0);
        for (int i = 0; i < rows.size(); i++)
        begin
            r = rows[i];
            c = cols[i];
            if (mode == 1)
                v = $urandom;
            else if (r == c && mode == 2 && r == bad)
                v = ($urandom_range(0, 1) == 0) ? 32'd0 : -int'($urandom_range(1, 1 << 20));
            else if (r == c)
                v = (4 * n + $urandom_range(1, 8)) * 65536 + $urandom_range(0, 65535);
            else
                v = rnd_pm(4 * 65536);
            if ($urandom_range(0, 7) == 0)
            begin
                // ignored upper entry, plus a row beyond the order when n < 8
                uc = $urandom_range(1, 7);
                send_elem(REQ_MATRIX, $urandom_range(0, uc - 1), uc, $urandom, 1'b0);
                if (n < 8)
                    send_elem(REQ_MATRIX, $urandom_range(n, 7), $urandom_range(0, 7),
                              $urandom, 1'b0);
            end
            send_elem(REQ_MATRIX, r, c, v, (i == rows.size() - 1) && !upper_last);
        end
        if (upper_last)
        begin
            c = $urandom_range(1, 7);
            send_elem(REQ_MATRIX, $urandom_range(0, c - 1), c, $urandom, 1'b1);
        end
    endtask

    task automatic load_rhs(bit wide);
        int n;
        int idx[$];
        int j;
        int t;
        logic [31:0] v;
        n = order_eff();
        for (int i = 0; i < n; i++)
            idx.push_back(i);
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = idx[i]; idx[i] = idx[j]; idx[j] = t;
        end
        if (n < 8 && $urandom_range(0, 3) == 0)
            send_elem(REQ_RHS, $urandom_range(n, 7), $urandom_range(0, 7), $urandom, 1'b0);
        for (int i = 0; i < n; i++)
        begin
            v = wide ? $urandom : rnd_pm(16 * 65536);
            send_elem(REQ_RHS, idx[i], $urandom_range(0, 7), v, i == n - 1);
        end
    endtask

    initial
    begin
        int pick;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        mismatches = 0;
        items_sent = 0;
        press_arm = 1'b0;
        order_reg = 8;
        fac_ok = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes at order 1
        write_order(1);
        send_elem(REQ_MATRIX, 0, 0, 32'h7fffffff, 1'b1);
        send_elem(REQ_RHS, 0, 0, 32'h80000000, 1'b1);
        send_elem(REQ_RHS, 7, 7, 32'hffffffff, 1'b0);
        send_elem(REQ_RHS, 0, 5, 32'h00010000, 1'b1);
        // solve with no factor, then a negative pivot
        write_order(2);
        send_elem(REQ_RHS, 1, 0, 32'h00010000, 1'b1);
        send_elem(REQ_MATRIX, 0, 0, 32'hffff0000, 1'b0);
        send_elem(REQ_MATRIX, 1, 0, 32'h00000000, 1'b0);
        send_elem(REQ_MATRIX, 1, 1, 32'h00010000, 1'b1);
        send_elem(REQ_RHS, 0, 0, 32'h00020000, 1'b0);
        send_elem(REQ_RHS, 1, 0, 32'h00030000, 1'b1);
        // factor started by an upper entry
        send_elem(REQ_MATRIX, 0, 0, 32'h00040000, 1'b0);
        send_elem(REQ_MATRIX, 1, 0, 32'h00010000, 1'b0);
        send_elem(REQ_MATRIX, 1, 1, 32'h00030000, 1'b0);
        send_elem(REQ_MATRIX, 0, 1, 32'h7fffffff, 1'b1);
        send_elem(REQ_RHS, 0, 0, 32'h00050000, 1'b0);
        send_elem(REQ_RHS, 1, 0, 32'hfffb0000, 1'b1);
        // order 0 acts as order 1
        write_order(0);
        send_elem(REQ_MATRIX, 0, 0, 32'h00000000, 1'b1);
        send_elem(REQ_MATRIX, 0, 0, 32'h00000001, 1'b1);
        send_elem(REQ_RHS, 0, 0, 32'h7fffffff, 1'b1);

        press_arm = 1'b1;
        write_order(8);
        load_matrix(0);
        load_rhs(1'b0);
        while (items_sent < 270)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    write_order(0);
                else if (pick == 1)
                    write_order(15);
                else if (pick <= 3)
                    write_order(8);
                else if (pick <= 6)
                    write_order($urandom_range(5, 7));
                else
                    write_order($urandom_range(1, 4));
                if ($urandom_range(0, 2) == 0)
                    load_rhs(1'b0);
            end
            pick = $urandom_range(0, 9);
            load_matrix(pick < 7 ? 0 : (pick < 9 ? 1 : 2));
            load_rhs($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 1) == 0)
                load_rhs($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 7) == 0)
            begin
                // a load without trigger invalidates the factor
                send_elem(REQ_MATRIX, 0, 0, 32'h00100000, 1'b0);
                load_rhs(1'b0);
            end
        end

        wait_idle();
        repeat (3000) @(posedge clk);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
